[rtl/utp_pkg.sv]
// ----------------------------------------------------------------------------
// utp_pkg
// Shared types, constants and the hex digit decode for the UUID text parser.
// ----------------------------------------------------------------------------
package utp_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned DIGIT_W  = 5;
  localparam int unsigned NIBBLE_W = 4;
  localparam int unsigned BYTES    = 16;
  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned ADDR_W   = 3;
  localparam int unsigned DATA_W   = 32;

  localparam logic [POS_W-1:0] LEN_WITH_DASHES = POS_W'(36);
  localparam logic [POS_W-1:0] LEN_NO_DASHES   = POS_W'(32);

  localparam logic [POS_W-1:0] DASH_POS_0 = POS_W'(8);
  localparam logic [POS_W-1:0] DASH_POS_1 = POS_W'(13);
  localparam logic [POS_W-1:0] DASH_POS_2 = POS_W'(18);
  localparam logic [POS_W-1:0] DASH_POS_3 = POS_W'(23);

  localparam logic [CHAR_W-1:0] CHAR_DIGIT_LO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DIGIT_HI  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_LO  = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_HI  = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_HI  = 8'h66;
  localparam logic [CHAR_W-1:0] UPPER_OFFSET   = 8'h37;
  localparam logic [CHAR_W-1:0] LOWER_OFFSET   = 8'h57;

  localparam logic REG_DASHES_PRESENT  = 1'b0;
  localparam logic REG_GUID_BYTE_ORDER = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_DIGIT = 2'd1,
    STATUS_TOO_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    logic                bad;
    logic [NIBBLE_W-1:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t        r;
    logic [CHAR_W-1:0] d;
    r.bad = 1'b0;
    d     = '0;
    if (c >= CHAR_DIGIT_LO && c <= CHAR_DIGIT_HI) begin
      d = c - CHAR_DIGIT_LO;
    end else if (c >= CHAR_UPPER_LO && c <= CHAR_UPPER_HI) begin
      d = c - UPPER_OFFSET;
    end else if (c >= CHAR_LOWER_LO && c <= CHAR_LOWER_HI) begin
      d = c - LOWER_OFFSET;
    end else begin
      r.bad = 1'b1;
    end
    r.value = d[NIBBLE_W-1:0];
    return r;
  endfunction

endpackage

[rtl/uuid_text_parser.sv]
// ----------------------------------------------------------------------------
// uuid_text_parser
// Parses the text form of a UUID, one character per transfer, into 16 bytes.
// ----------------------------------------------------------------------------
// One character is taken per clock cycle while in_ready is high: each transfer is
// decoded in a single step from the position, nibble and byte registers into
// those registers and, on the end-of-string flag, into the output register,
// so the result of a string appears in the cycle after its last character. The
// input stays ready while a result waits, as long as that result is taken in
// the same cycle or no further end-of-string arrives. Registers: 0x0
// dashes_present (reset 1), 0x4 guid_byte_order (reset 0), bit 0 each.
// Only the 32 hex digits are checked; dash positions are skipped unchecked
// and trailing text is ignored. Halves read zero on any error status.
module uuid_text_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [utp_pkg::ADDR_W-1:0]    paddr,
  input  logic [utp_pkg::DATA_W-1:0]    pwdata,
  output logic [utp_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [utp_pkg::CHAR_W-1:0]    char_code,
  input  logic                          end_of_string,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [utp_pkg::HALF_W-1:0]    uuid_bytes_low_half,
  output logic [utp_pkg::HALF_W-1:0]    uuid_bytes_high_half,
  output utp_pkg::status_t              parse_status
);
  import utp_pkg::*;

  logic                dashes_present;
  logic                guid_byte_order;
  logic [POS_W-1:0]    char_position;
  logic [NIBBLE_W-1:0] nibble_hold;
  logic                error_seen;
  logic [CHAR_W-1:0]   byte_store [BYTES];

  logic                cfg_write;
  logic                in_fire;
  logic [POS_W-1:0]    total;
  logic                pos_open;
  logic                is_dash;
  logic [POS_W-1:0]    digit_full;
  logic [DIGIT_W-1:0]  digit;
  logic                take;
  logic                byte_write;
  logic [SLOT_W-1:0]   byte_index;
  logic [SLOT_W-1:0]   slot;
  hex_t                hex;
  logic [CHAR_W-1:0]   byte_value;
  logic [POS_W-1:0]    char_position_next;
  logic                error_seen_next;
  logic [CHAR_W-1:0]   store_next [BYTES];
  logic [HALF_W-1:0]   low_next;
  logic [HALF_W-1:0]   high_next;
  status_t             status_next;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign in_ready  = !out_valid || out_ready || !end_of_string;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_DASHES_PRESENT:  prdata[0] = dashes_present;
      REG_GUID_BYTE_ORDER: prdata[0] = guid_byte_order;
      default:             prdata[0] = 1'b0;
    endcase
  end

  always_comb begin
    total    = dashes_present ? LEN_WITH_DASHES : LEN_NO_DASHES;
    pos_open = char_position < total;
    is_dash  = dashes_present && (char_position == DASH_POS_0 ||
               char_position == DASH_POS_1 || char_position == DASH_POS_2 ||
               char_position == DASH_POS_3);
    if (dashes_present) begin
      digit_full = char_position
                 - POS_W'(char_position > DASH_POS_0)
                 - POS_W'(char_position > DASH_POS_1)
                 - POS_W'(char_position > DASH_POS_2)
                 - POS_W'(char_position > DASH_POS_3);
    end else begin
      digit_full = char_position;
    end
    digit      = digit_full[DIGIT_W-1:0];
    take       = pos_open && !is_dash;
    byte_write = take && digit[0];
    byte_index = digit[DIGIT_W-1:1];

    slot = byte_index;
    if (guid_byte_order) begin
      if (byte_index < SLOT_W'(4)) begin
        slot = SLOT_W'(3) - byte_index;
      end else if (byte_index < SLOT_W'(8)) begin
        slot = byte_index ^ SLOT_W'(1);
      end
    end

    hex = hex_decode(char_code);
    if (hex.bad) begin
      hex.value = '0;
    end
    byte_value = {nibble_hold, hex.value};

    char_position_next = pos_open ? char_position + POS_W'(1) : char_position;
    error_seen_next    = error_seen || (take && hex.bad);

    for (int i = 0; i < BYTES; i++) begin
      store_next[i] = (byte_write && slot == SLOT_W'(i)) ? byte_value : byte_store[i];
    end

    for (int k = 0; k < BYTES / 2; k++) begin
      low_next[HALF_W-1-CHAR_W*k -: CHAR_W]  = store_next[k];
      high_next[HALF_W-1-CHAR_W*k -: CHAR_W] = store_next[k + BYTES / 2];
    end

    priority if (char_position_next < total) begin
      status_next = STATUS_TOO_SHORT;
    end else if (error_seen_next) begin
      status_next = STATUS_BAD_DIGIT;
    end else begin
      status_next = STATUS_OK;
    end
    if (status_next != STATUS_OK) begin
      low_next  = '0;
      high_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dashes_present  <= 1'b1;
      guid_byte_order <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DASHES_PRESENT:  dashes_present  <= pwdata[0];
        REG_GUID_BYTE_ORDER: guid_byte_order <= pwdata[0];
        default:             dashes_present  <= dashes_present;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      nibble_hold   <= '0;
      error_seen    <= 1'b0;
    end else if (in_fire) begin
      if (end_of_string) begin
        char_position <= '0;
        nibble_hold   <= '0;
        error_seen    <= 1'b0;
      end else begin
        char_position <= char_position_next;
        error_seen    <= error_seen_next;
        if (take && !digit[0]) begin
          nibble_hold <= hex.value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && byte_write) begin
      byte_store[slot] <= byte_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && end_of_string) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && end_of_string) begin
      uuid_bytes_low_half  <= low_next;
      uuid_bytes_high_half <= high_next;
      parse_status         <= status_next;
    end
  end

endmodule
